/* sv/gif_pkg.sv */
// Shared types and constants for the GIF LZW decoder.
package gif_pkg;
	localparam int unsigned TableEntriesDefault = 4096;
	localparam logic [3:0] MinCodeReset = 4'd8;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic       byte_taken;
		logic       pixel_valid;
		logic [7:0] pixel_index;
		logic       done_res;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_WAIT,
		ST_EMIT,
		ST_POP
	} state_t;
endpackage

/* sv/gif_lzw_decoder.sv */
// Top level of the GIF LZW decoder: sequencer, tables, pixel stack and bit buffer.
// Each accepted item performs one step. A byte absorb, an idle step and a decode of a
// clear code, an end code or the first code after a clear pass through the accept and
// then the result register. A pixel pop passes through accept, a registered stack read
// and the result. An ordinary decode walks the prefix chain through the table memory,
// an address step and then a registered read per chain link, before the emit step.
// A result waits in the output register and the next item is accepted only after it is
// taken.
module gif_lzw_decoder #(
	parameter int unsigned TABLE_ENTRIES = gif_pkg::TableEntriesDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [3:0]       cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  gif_pkg::in_item_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output gif_pkg::out_item_t out_data
);
	import gif_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int SW = AW + 1;
	localparam int StackDepth = TABLE_ENTRIES + 1;

	// Clamp a minimum code size to the supported range
	function automatic logic [3:0] eff_size(input logic [3:0] v);
		if (v < 4'd2) return 4'd2;
		if (v > 4'd8) return 4'd8;
		return v;
	endfunction

	// Tables and pixel stack
	logic [11:0] prefix_mem [TABLE_ENTRIES];
	logic [7:0]  suffix_mem [TABLE_ENTRIES];
	logic [7:0]  stack_mem  [StackDepth];

	logic [3:0]  msize_q;
	logic [SW-1:0] stack_count_q;
	logic [3:0]  code_width_q;
	logic [12:0] next_slot_q, slot_limit_q;
	logic [11:0] old_code_q, cur_q, code_q;
	logic [7:0]  first_char_q;
	logic [18:0] bit_buffer_q;
	logic [4:0]  bit_count_q;
	logic [7:0]  block_rem_q;
	logic        after_clear_q, finished_q;
	state_t      state_q;
	logic [11:0] rd_prefix_q;
	logic [7:0]  rd_suffix_q, rd_stack_q;
	out_item_t   res_q;
	logic        res_v_q;

	// Effective minimum code size and derived codes
	logic [3:0]  m;
	logic [12:0] clear_c, first_free;
	always_comb begin
		priority if (msize_q < 4'd2) m = 4'd2;
		else if (msize_q > 4'd8) m = 4'd8;
		else m = msize_q;
		clear_c = 13'd1 << m;
		first_free = clear_c + 13'd2;
	end

	logic [12:0] code_now;
	assign code_now = 13'(bit_buffer_q & ((19'd1 << code_width_q) - 19'd1));
	assign in_ready = (state_q == ST_IDLE) && !res_v_q;
	assign out_valid = res_v_q;
	assign out_data = res_q;

	logic accept;
	assign accept = in_valid && in_ready;

	// Classify the step an accepted item performs
	logic do_pop, do_absorb, do_decode, is_end, is_clear, take_byte, end_block;
	logic walk_start, res_set;
	assign do_pop = stack_count_q != '0;
	assign do_absorb = !do_pop && !finished_q && (bit_count_q < {1'b0, code_width_q});
	assign do_decode = !do_pop && !finished_q && !do_absorb;
	assign is_end = code_now == clear_c + 13'd1;
	assign is_clear = code_now == clear_c;
	assign take_byte = do_absorb && in_data.action;
	assign end_block = take_byte && block_rem_q == 8'd0 && in_data.data_byte == 8'd0;
	assign walk_start = do_decode && !is_end && !is_clear && !after_clear_q;
	assign res_set = (accept && !do_pop && !walk_start) || state_q == ST_POP ||
		state_q == ST_EMIT;

	logic walk_go;
	assign walk_go = ({1'b0, cur_q} >= first_free) &&
		(32'(stack_count_q) < StackDepth - 1);

	// Memory reads for pop and chain walk
	always_ff @(posedge clk) begin
		rd_prefix_q <= prefix_mem[cur_q[AW-1:0]];
		rd_suffix_q <= suffix_mem[cur_q[AW-1:0]];
		rd_stack_q  <= stack_mem[stack_count_q - SW'(1)];
	end

	// Stack and table writes
	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT)
			stack_mem[stack_count_q] <= rd_suffix_q;
		if (accept && do_decode && !is_end && !is_clear) begin
			if (after_clear_q) begin
				stack_mem[stack_count_q] <= (code_now >= next_slot_q) ? 8'd0 : code_now[7:0];
			end else if (code_now >= next_slot_q) begin
				stack_mem[stack_count_q] <= first_char_q;
			end
		end
		if (state_q == ST_EMIT) begin
			if (32'(stack_count_q) < StackDepth)
				stack_mem[stack_count_q] <= cur_q[7:0];
			if (next_slot_q < slot_limit_q) begin
				suffix_mem[next_slot_q[AW-1:0]] <= cur_q[7:0];
				prefix_mem[next_slot_q[AW-1:0]] <= old_code_q;
			end
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msize_q <= MinCodeReset;
			state_q <= ST_IDLE;
			res_v_q <= 1'b0;
			stack_count_q <= '0;
			bit_buffer_q <= '0;
			bit_count_q <= '0;
			block_rem_q <= '0;
			after_clear_q <= 1'b0;
			finished_q <= 1'b0;
			old_code_q <= '0;
			first_char_q <= '0;
			cur_q <= '0;
			code_q <= '0;
			res_q <= '0;
			code_width_q <= eff_size(MinCodeReset) + 4'd1;
			next_slot_q <= (13'd1 << eff_size(MinCodeReset)) + 13'd2;
			slot_limit_q <= 13'd1 << (eff_size(MinCodeReset) + 4'd1);
		end else if (cfg_we) begin
			// restart the decoder with the new code size
			msize_q <= cfg_data;
			state_q <= ST_IDLE;
			res_v_q <= 1'b0;
			stack_count_q <= '0;
			bit_buffer_q <= '0;
			bit_count_q <= '0;
			block_rem_q <= '0;
			after_clear_q <= 1'b0;
			finished_q <= 1'b0;
			old_code_q <= '0;
			first_char_q <= '0;
			cur_q <= '0;
			code_q <= '0;
			res_q <= '0;
			code_width_q <= eff_size(cfg_data) + 4'd1;
			next_slot_q <= (13'd1 << eff_size(cfg_data)) + 13'd2;
			slot_limit_q <= 13'd1 << (eff_size(cfg_data) + 4'd1);
		end else begin
			// load a new result or drop the one just taken
			res_v_q <= res_set || (res_v_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!do_pop && !walk_start)
							res_q <= '{byte_taken: take_byte, pixel_valid: 1'b0,
								pixel_index: 8'd0,
								done_res: finished_q || end_block || (do_decode && is_end)};
						if (do_pop) begin
							// pop: memory read lands next cycle
							stack_count_q <= stack_count_q - SW'(1);
							state_q <= ST_POP;
						end else if (do_absorb) begin
							if (take_byte) begin
								if (block_rem_q == 8'd0) begin
									if (in_data.data_byte == 8'd0) finished_q <= 1'b1;
									else block_rem_q <= in_data.data_byte;
								end else begin
									bit_buffer_q <= bit_buffer_q |
										(19'(in_data.data_byte) << bit_count_q);
									bit_count_q <= bit_count_q + 5'd8;
									block_rem_q <= block_rem_q - 8'd1;
								end
							end
						end else if (do_decode) begin
							// decode one code
							bit_buffer_q <= bit_buffer_q >> code_width_q;
							bit_count_q <= bit_count_q - {1'b0, code_width_q};
							if (is_end) begin
								finished_q <= 1'b1;
							end else if (is_clear) begin
								code_width_q <= m + 4'd1;
								next_slot_q <= first_free;
								slot_limit_q <= 13'd1 << (m + 4'd1);
								after_clear_q <= 1'b1;
							end else if (after_clear_q) begin
								old_code_q <= (code_now >= next_slot_q) ? 12'd0 : code_now[11:0];
								first_char_q <= (code_now >= next_slot_q) ? 8'd0 : code_now[7:0];
								stack_count_q <= stack_count_q + SW'(1);
								after_clear_q <= 1'b0;
							end else begin
								code_q <= code_now[11:0];
								if (code_now >= next_slot_q) begin
									cur_q <= old_code_q;
									stack_count_q <= stack_count_q + SW'(1);
								end else cur_q <= code_now[11:0];
								state_q <= ST_WALK;
							end
						end
					end
				end
				ST_POP: begin
					// hand out the popped pixel
					state_q <= ST_IDLE;
					res_q <= '{byte_taken: 1'b0, pixel_valid: 1'b1, pixel_index: rd_stack_q,
						done_res: finished_q};
				end
				ST_WALK: begin
					// address is cur_q; wait for the registered read
					if (walk_go) state_q <= ST_WAIT;
					else state_q <= ST_EMIT;
				end
				ST_WAIT: begin
					state_q <= ST_WALK;
					stack_count_q <= stack_count_q + SW'(1);
					cur_q <= rd_prefix_q;
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
					res_q <= '{byte_taken: 1'b0, pixel_valid: 1'b0, pixel_index: 8'd0,
						done_res: finished_q};
					if (32'(stack_count_q) < StackDepth)
						stack_count_q <= stack_count_q + SW'(1);
					begin : grow
						logic [12:0] ns;
						ns = next_slot_q;
						if (next_slot_q < slot_limit_q) begin
							first_char_q <= cur_q[7:0];
							ns = next_slot_q + 13'd1;
							next_slot_q <= ns;
							old_code_q <= code_q;
						end
						if (ns >= slot_limit_q && 32'(slot_limit_q) < TABLE_ENTRIES) begin
							slot_limit_q <= slot_limit_q << 1;
							code_width_q <= code_width_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* sim/gif_lzw_decoder_test.sv */
// Self-checking regression bench for the GIF LZW decoder with a built-in predictor.
module gif_lzw_decoder_test;
	import gif_pkg::*;

	localparam int unsigned TABLE_SIZE = 4096;
	localparam int unsigned CYCLE_LIMIT = 6000000;
	localparam int unsigned TARGET_ITEMS = 1550;

	// Predict decoder results and compare them against the output channel.
	class lzw_scoreboard;
		bit [3:0] size_reg;
		bit [11:0] prefix_mem[TABLE_SIZE];
		bit [7:0] suffix_mem[TABLE_SIZE];
		bit [7:0] pixel_mem[TABLE_SIZE + 1];
		int unsigned depth, width, slot, slot_cap, old_code, first_char;
		int unsigned bits_held, block_left;
		bit [31:0] bit_acc;
		bit after_clear, finished;
		out_item_t pending[$];
		int unsigned fails, items;

		function new();
			size_reg = MinCodeReset;
			restart();
		endfunction

		function int unsigned eff_size();
			if (size_reg < 2) return 2;
			if (size_reg > 8) return 8;
			return size_reg;
		endfunction

		function void restart();
			depth = 0;
			width = eff_size() + 1;
			slot = (1 << eff_size()) + 2;
			slot_cap = 1 << width;
			old_code = 0;
			first_char = 0;
			bit_acc = 0;
			bits_held = 0;
			block_left = 0;
			after_clear = 0;
			finished = 0;
		endfunction

		function void set_size(bit [3:0] v);
			size_reg = v;
			restart();
		endfunction

		function void push_pixel(int unsigned v);
			if (depth < TABLE_SIZE + 1) begin
				pixel_mem[depth] = v[7:0];
				depth++;
			end
		endfunction

		function void decode_code();
			int unsigned m, clr, ff, code, cur, idx;
			m = eff_size();
			clr = 1 << m;
			ff = clr + 2;
			code = bit_acc & ((1 << width) - 1);
			bit_acc = bit_acc >> width;
			bits_held -= width;
			if (code == clr + 1) begin
				finished = 1;
				return;
			end
			if (code == clr) begin
				width = m + 1;
				slot = ff;
				slot_cap = 1 << width;
				after_clear = 1;
				return;
			end
			if (after_clear) begin
				if (code >= slot) code = 0;
				old_code = code;
				first_char = code & 8'hFF;
				push_pixel(code);
				after_clear = 0;
				return;
			end
			cur = code;
			if (cur >= slot) begin
				cur = old_code;
				push_pixel(first_char);
			end
			// walk the prefix chain down to a root code
			while (cur >= ff && depth < TABLE_SIZE) begin
				idx = cur & (TABLE_SIZE - 1);
				push_pixel(suffix_mem[idx]);
				cur = prefix_mem[idx];
			end
			push_pixel(cur);
			if (slot < slot_cap) begin
				idx = slot & (TABLE_SIZE - 1);
				first_char = cur & 8'hFF;
				suffix_mem[idx] = first_char[7:0];
				prefix_mem[idx] = old_code[11:0];
				slot++;
				old_code = code & 12'hFFF;
			end
			if (slot >= slot_cap && slot_cap < TABLE_SIZE) begin
				slot_cap = slot_cap << 1;
				width++;
			end
		endfunction

		// Note an accepted item; return whether its byte is consumed.
		function bit note_item(in_item_t it);
			out_item_t res;
			res = '0;
			items++;
			if (depth > 0) begin
				depth--;
				res.pixel_valid = 1;
				res.pixel_index = pixel_mem[depth];
			end else if (finished) begin
			end else if (bits_held < width) begin
				if (it.action) begin
					res.byte_taken = 1;
					if (block_left == 0) begin
						if (it.data_byte == 0) finished = 1;
						else block_left = it.data_byte;
					end else begin
						bit_acc = bit_acc | (32'(it.data_byte) << bits_held);
						bits_held += 8;
						block_left--;
					end
				end
			end else begin
				decode_code();
			end
			res.done_res = finished;
			pending.push_back(res);
			return res.byte_taken;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$error("unexpected item: %h", got);
				fails++;
				return;
			end
			want = pending.pop_front();
			if (got.byte_taken !== want.byte_taken) begin
				$error("byte_taken expected %0d got %0d", want.byte_taken, got.byte_taken);
				fails++;
			end
			if (got.pixel_valid !== want.pixel_valid) begin
				$error("pixel_valid expected %0d got %0d", want.pixel_valid, got.pixel_valid);
				fails++;
			end
			if (got.pixel_index !== want.pixel_index) begin
				$error("pixel_index expected %0d got %0d", want.pixel_index, got.pixel_index);
				fails++;
			end
			if (got.done_res !== want.done_res) begin
				$error("done_res expected %0d got %0d", want.done_res, got.done_res);
				fails++;
			end
		endfunction

		function bit drained();
			return finished && depth == 0;
		endfunction
	endclass

	logic clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
	logic [3:0] cfg_data;
	in_item_t in_data;
	out_item_t out_data;

	lzw_scoreboard sb = new();
	int unsigned sender_idle_pct, receiver_stall_pct, hold_left, cycles;

	gif_lzw_decoder u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Count cycles and end a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("gif_lzw_decoder regression: fail");
			$finish;
		end
	end

	// Take results, stalling at random or for a long hold-off.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Offer one item, idling first at random; return whether its byte was taken.
	task automatic offer_item(in_item_t it, output bit taken);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		taken = sb.note_item(it);
	endtask

	// Build an image data stream of sub-blocks, mirroring table growth.
	function automatic void build_stream(int unsigned raw, int unsigned ncodes,
			ref bit [7:0] stream[$]);
		int unsigned m, clr, ff, slot, cap, w, code, hi, lo, n, len, r;
		bit after_clr;
		bit [31:0] acc;
		bit [7:0] data[$];
		m = (raw < 2) ? 2 : (raw > 8) ? 8 : raw;
		clr = 1 << m;
		ff = clr + 2;
		slot = ff;
		w = m + 1;
		cap = 1 << w;
		after_clr = 0;
		acc = 0;
		n = 0;
		stream = {};
		for (int i = -1; i <= int'(ncodes); i++) begin
			r = $urandom_range(99);
			if (i == -1) begin
				if (r >= 70) continue;
				code = clr;
			end else if (i == int'(ncodes)) begin
				if (r >= 75) break;
				code = clr + 1;
			end else if (r < 4) begin
				code = clr;
			end else if (after_clr) begin
				code = (r < 15) ? $urandom_range((1 << w) - 1, slot) : $urandom_range(clr - 1, 0);
			end else if (r < 45) begin
				code = $urandom_range(clr - 1, 0);
			end else begin
				hi = (slot < TABLE_SIZE) ? slot : TABLE_SIZE - 1;
				lo = (hi >= ff + 8) ? hi - 8 : ff;
				code = $urandom_range(hi, lo);
			end
			acc = acc | (code << n);
			n += w;
			while (n >= 8) begin
				data.push_back(acc[7:0]);
				acc = acc >> 8;
				n -= 8;
			end
			// track the decoder's width and next free slot
			if (code == clr) begin
				w = m + 1;
				slot = ff;
				cap = 1 << w;
				after_clr = 1;
			end else if (after_clr) begin
				after_clr = 0;
			end else begin
				if (slot < cap) slot++;
				if (slot >= cap && cap < TABLE_SIZE) begin
					cap = cap << 1;
					w++;
				end
			end
		end
		if (n > 0) data.push_back(acc[7:0]);
		// split into sub-blocks and close with a zero-length block
		while (data.size() > 0) begin
			len = ($urandom_range(9) == 0) ? 255 : $urandom_range(16, 1);
			if (len > data.size()) len = data.size();
			stream.push_back(len[7:0]);
			repeat (len) stream.push_back(data.pop_front());
		end
		stream.push_back(8'd0);
	endfunction

	// Decode one stream until the end is seen and the stack is drained, then three idle steps.
	task automatic run_stream(int unsigned raw, int unsigned ncodes);
		bit [7:0] stream[$];
		int unsigned pos;
		in_item_t it;
		bit taken;
		build_stream(raw, ncodes, stream);
		pos = 0;
		while (!sb.drained()) begin
			it.action = (pos < stream.size()) && ($urandom_range(9) != 0);
			it.data_byte = (pos < stream.size() && it.action) ? stream[pos] : 8'($urandom);
			offer_item(it, taken);
			if (taken) pos++;
		end
		repeat (3) begin
			it.action = 1'($urandom_range(1));
			it.data_byte = 8'($urandom);
			offer_item(it, taken);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		int unsigned sizes[12];
		int unsigned s;
		sizes = '{2, 15, 0, 8, 1, 3, 9, 5, 4, 6, 7, 2};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_left = 0;
		cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		s = 0;
		while (sb.items < TARGET_ITEMS) begin
			// settle, then load a new code size between streams
			while (sb.pending.size() != 0) @(posedge clk);
			repeat (8) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_data <= 4'(sizes[s % 12]);
			@(posedge clk);
			cfg_we <= 1'b0;
			sb.set_size(4'(sizes[s % 12]));
			case (s % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 88;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 88;
				end
				default: begin
					sender_idle_pct = 6;
					receiver_stall_pct = 6;
				end
			endcase
			if (s == 5) hold_left = 400;
			run_stream(sizes[s % 12], (s < 4) ? $urandom_range(6, 3) : $urandom_range(60, 10));
			s++;
		end
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fails == 0) begin
			$display("gif_lzw_decoder regression: pass");
		end else begin
			$display("gif_lzw_decoder regression: fail");
		end
		$finish;
	end
endmodule

/* filelist.f */
sv/gif_pkg.sv
sv/gif_lzw_decoder.sv
sim/gif_lzw_decoder_test.sv
